@@ rtl/hbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_pkg
// Shared codes and controller/datapath interface types of the buffer cache
// tag store.
// ----------------------------------------------------------------------------
package hbc_pkg;

  // request codes
  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // reference count limits
  localparam logic [5:0] COUNT_MAX = 6'd63;
  localparam logic [5:0] COUNT_ONE = 6'd1;

  // bits of the block number folded into the bucket remainder
  localparam int BLOCK_BITS = 32;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_EVAL,
    ST_FETCH,
    ST_ENTRY,
    ST_SWEEP,
    ST_RESP
  } hbc_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic cnt_clr;
    logic clear_wr;
    logic mod_step;
    logic scan_step;
    logic eval_get;
    logic fetch;
    logic eval_entry;
    logic sweep_step;
  } hbc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_get;
    logic in_idx_ok;
    logic clear_done;
    logic mod_done;
    logic scan_done;
    logic need_sweep;
  } hbc_stat_t;

endpackage

@@ rtl/hashed_buffer_cache_tags.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_buffer_cache_tags
// Tag store of a hashed LRU disk buffer cache: get, release, pin and unpin.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on the out_ ports for one cycle with out_valid and cannot be held
// off. After reset the block runs a clearing pass over all NUM_BUFFERS
// entries with busy high. A get folds the block number into its bucket, one
// byte a cycle, then scans the entry memory one entry a cycle for a hit and
// a victim, and on a miss that finds a victim runs a rank sweep. Release,
// pin and unpin sweep the ranks only when a release frees the entry. The
// entry memory has a single read port.
module hashed_buffer_cache_tags #(
  parameter int NUM_BUFFERS = 32,
  parameter int NUM_BUCKETS = 13
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_device_id,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_entry_index,
  output logic        out_valid,
  output logic [4:0]  out_entry_out,
  output logic        out_hit,
  output logic        out_need_read,
  output logic [1:0]  out_status
);

  hbc_pkg::hbc_cmd_t  cmd;
  hbc_pkg::hbc_stat_t stat;

  // sequencer
  hbc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // entry store and arithmetic
  hbc_datapath #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_command      (in_command),
    .in_device_id    (in_device_id),
    .in_block_number (in_block_number),
    .in_entry_index  (in_entry_index),
    .out_entry_out   (out_entry_out),
    .out_hit         (out_hit),
    .out_need_read   (out_need_read),
    .out_status      (out_status)
  );

endmodule

@@ rtl/hbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/hbc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_datapath
// Entry store, bucket remainder unit, hit and victim scan, rank sweep and
// result registers.
// ----------------------------------------------------------------------------
module hbc_datapath #(
  parameter int NUM_BUFFERS = 32,
  parameter int NUM_BUCKETS = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hbc_pkg::hbc_cmd_t  cmd,
  output hbc_pkg::hbc_stat_t stat,
  input  logic [1:0]         in_command,
  input  logic [7:0]         in_device_id,
  input  logic [31:0]        in_block_number,
  input  logic [4:0]         in_entry_index,
  output logic [4:0]         out_entry_out,
  output logic               out_hit,
  output logic               out_need_read,
  output logic [1:0]         out_status
);

  localparam int AW  = $clog2(NUM_BUFFERS);
  localparam int BW  = $clog2(NUM_BUCKETS + 1);
  localparam int MW  = BW + 1;
  localparam int CW  = $clog2((NUM_BUFFERS > 32 ? NUM_BUFFERS : 32) + 1);
  localparam int DW  = 8 + 32 + 1 + 6 + BW + AW;
  // field offsets inside one stored entry
  localparam int O_RANK  = 0;
  localparam int O_BKT   = AW;
  localparam int O_CNT   = AW + BW;
  localparam int O_VALID = AW + BW + 6;
  localparam int O_BLK   = AW + BW + 7;
  localparam int O_DEV   = AW + BW + 39;
  localparam logic [AW-1:0] RANK_TOP  = AW'(NUM_BUFFERS - 1);
  localparam logic [CW-1:0] CNT_N     = CW'(NUM_BUFFERS);
  localparam logic [CW-1:0] CNT_LASTE = CW'(NUM_BUFFERS - 1);
  localparam logic [CW-1:0] CNT_MODE  = CW'(hbc_pkg::BLOCK_BITS / 8 - 1);
  localparam logic [MW-1:0] BKT_M     = MW'(NUM_BUCKETS);
  // byte fold of the remainder: x = rem * 256 + byte, x mod M by reciprocal
  localparam int XW  = BW + 8;
  localparam int SH  = XW + BW;
  localparam int RW  = SH + 1;
  localparam int PW  = XW + SH;
  localparam longint RECIP_L = ((longint'(1) << SH) + longint'(NUM_BUCKETS) - longint'(1)) /
                               longint'(NUM_BUCKETS);
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  localparam logic [XW-1:0] BKT_X = XW'(NUM_BUCKETS);

  // request registers
  logic [1:0]    cmd_r;
  logic [7:0]    dev_r;
  logic [31:0]   blk_r;
  logic [4:0]    idx_r;
  logic [31:0]   mod_sh_r;
  logic [MW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] cnt_r;

  // scan and sweep pipeline
  logic          scan_v_r, sweep_v_r;
  logic [AW-1:0] pipe_idx_r;

  // best hit and victim
  logic          hit_found_r;
  logic [AW-1:0] hit_idx_r, hit_rank_r;
  logic [5:0]    hit_cnt_r;
  logic          hit_valid_r;
  logic          vic_found_r;
  logic [AW-1:0] vic_idx_r, vic_rank_r;
  logic [BW-1:0] vic_k_r;

  // sweep target
  logic [AW-1:0] tgt_idx_r, old_rank_r;
  logic [DW-1:0] tgt_rec_r;

  // results
  logic [4:0]    res_entry_r;
  logic          res_hit_r, res_need_r;
  logic [1:0]    res_status_r;

  // memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  hbc_ram #(.WIDTH(DW), .DEPTH(NUM_BUFFERS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // fields of the entry read last cycle
  logic [7:0]    rd_dev;
  logic [31:0]   rd_blk;
  logic          rd_valid;
  logic [5:0]    rd_cnt;
  logic [BW-1:0] rd_bkt;
  logic [AW-1:0] rd_rank;
  assign rd_dev   = rdata[O_DEV +: 8];
  assign rd_blk   = rdata[O_BLK +: 32];
  assign rd_valid = rdata[O_VALID];
  assign rd_cnt   = rdata[O_CNT +: 6];
  assign rd_bkt   = rdata[O_BKT +: BW];
  assign rd_rank  = rdata[O_RANK +: AW];

  logic [BW-1:0] home;
  assign home = rem_r[BW-1:0];

  logic [8:0]    idx9, in_idx9;
  logic [AW-1:0] idx_a;
  logic [4:0]    hit_idx5, vic_idx5;
  assign idx9      = {4'b0, idx_r};
  assign in_idx9   = {4'b0, in_entry_index};
  assign idx_a     = idx9[AW-1:0];
  assign hit_idx5  = 5'(9'(hit_idx_r));
  assign vic_idx5  = 5'(9'(vic_idx_r));

  logic cnt_lt_n;
  assign cnt_lt_n = cnt_r < CNT_N;

  // bucket order of the scanned entry, home bucket last
  logic [MW-1:0] kdiff;
  logic [BW-1:0] kval;
  always_comb begin
    kdiff = MW'(rd_bkt) + BKT_M - MW'(home);
    if (kdiff >= BKT_M) begin
      kdiff = kdiff - BKT_M;
    end
    kval = (kdiff == '0) ? BKT_M[BW-1:0] : kdiff[BW-1:0];
  end

  logic hit_take, vic_take;
  assign hit_take = scan_v_r && rd_bkt == home && rd_dev == dev_r && rd_blk == blk_r &&
                    (!hit_found_r || rd_rank > hit_rank_r);
  assign vic_take = scan_v_r && rd_cnt == '0 &&
                    (!vic_found_r || kval < vic_k_r ||
                     (kval == vic_k_r && rd_rank < vic_rank_r));

  // remainder step, one block byte per cycle
  logic [XW-1:0] mod_x, mod_q, mod_qm, mod_d;
  logic [PW-1:0] mod_prod;
  always_comb begin
    mod_x    = {home, mod_sh_r[31:24]};
    mod_prod = PW'(mod_x) * PW'(RECIP);
    mod_q    = mod_prod[SH +: XW];
    mod_qm   = mod_q * BKT_X;
    mod_d    = mod_x - mod_qm;
    rem_nxt  = {1'b0, mod_d[BW-1:0]};
  end

  // status to the controller
  logic [5:0] ent_cnt_inc;
  assign ent_cnt_inc = (rd_cnt < hbc_pkg::COUNT_MAX) ? rd_cnt + 6'd1 : rd_cnt;
  always_comb begin
    stat.in_get     = in_command == hbc_pkg::CMD_GET;
    stat.in_idx_ok  = in_idx9 < 9'(NUM_BUFFERS);
    stat.clear_done = cnt_r == CNT_LASTE;
    stat.mod_done   = cnt_r == CNT_MODE;
    stat.scan_done  = cnt_r == CNT_N;
    stat.need_sweep = (cmd.eval_get && !hit_found_r && vic_found_r) ||
                      (cmd.eval_entry && cmd_r == hbc_pkg::CMD_RELEASE &&
                       rd_cnt == hbc_pkg::COUNT_ONE);
  end

  // memory access selection
  always_comb begin
    we    = 1'b0;
    waddr = pipe_idx_r;
    wdata = rdata;
    raddr = cnt_r[AW-1:0];
    if (cmd.fetch) begin
      raddr = idx_a;
    end
    if (cmd.clear_wr) begin
      we    = 1'b1;
      waddr = cnt_r[AW-1:0];
      wdata = {8'd0, 32'd0, 1'b0, 6'd0, {BW{1'b0}}, cnt_r[AW-1:0]};
    end else if (cmd.eval_get && hit_found_r) begin
      we    = 1'b1;
      waddr = hit_idx_r;
      wdata = {dev_r, blk_r, 1'b1,
               (hit_cnt_r < hbc_pkg::COUNT_MAX) ? hit_cnt_r + 6'd1 : hit_cnt_r,
               home, hit_rank_r};
    end else if (cmd.eval_entry) begin
      waddr = idx_a;
      if (cmd_r == hbc_pkg::CMD_PIN) begin
        we    = 1'b1;
        wdata = {rd_dev, rd_blk, rd_valid, ent_cnt_inc, rd_bkt, rd_rank};
      end else if (rd_cnt != '0 && !stat.need_sweep) begin
        we    = 1'b1;
        wdata = {rd_dev, rd_blk, rd_valid, rd_cnt - 6'd1, rd_bkt, rd_rank};
      end
    end else if (sweep_v_r) begin
      if (pipe_idx_r == tgt_idx_r) begin
        we    = 1'b1;
        wdata = tgt_rec_r;
      end else if (rd_rank > old_rank_r) begin
        we    = 1'b1;
        wdata = {rd_dev, rd_blk, rd_valid, rd_cnt, rd_bkt, rd_rank - AW'(1)};
      end
    end
  end

  // step counter and pipeline flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      scan_v_r  <= 1'b0;
      sweep_v_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clear_wr || cmd.mod_step || cmd.scan_step || cmd.sweep_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
      scan_v_r  <= cmd.scan_step && cnt_lt_n;
      sweep_v_r <= cmd.sweep_step && cnt_lt_n;
    end
  end

  // request, scan, target and result registers
  always_ff @(posedge clk) begin
    pipe_idx_r <= cnt_r[AW-1:0];
    if (cmd.load) begin
      cmd_r        <= in_command;
      dev_r        <= in_device_id;
      blk_r        <= in_block_number;
      mod_sh_r     <= in_block_number;
      idx_r        <= in_entry_index;
      rem_r        <= '0;
      hit_found_r  <= 1'b0;
      vic_found_r  <= 1'b0;
      res_entry_r  <= in_entry_index;
      res_hit_r    <= 1'b0;
      res_need_r   <= 1'b0;
      res_status_r <= hbc_pkg::STAT_OK;
    end
    if (cmd.mod_step) begin
      rem_r    <= rem_nxt;
      mod_sh_r <= {mod_sh_r[23:0], 8'd0};
    end
    if (hit_take) begin
      hit_found_r <= 1'b1;
      hit_idx_r   <= pipe_idx_r;
      hit_rank_r  <= rd_rank;
      hit_cnt_r   <= rd_cnt;
      hit_valid_r <= rd_valid;
    end
    if (vic_take) begin
      vic_found_r <= 1'b1;
      vic_idx_r   <= pipe_idx_r;
      vic_rank_r  <= rd_rank;
      vic_k_r     <= kval;
    end
    // get decision
    if (cmd.eval_get) begin
      if (hit_found_r) begin
        res_entry_r <= hit_idx5;
        res_hit_r   <= 1'b1;
        res_need_r  <= !hit_valid_r;
      end else if (vic_found_r) begin
        res_entry_r <= vic_idx5;
        res_need_r  <= 1'b1;
        tgt_idx_r   <= vic_idx_r;
        old_rank_r  <= vic_rank_r;
        tgt_rec_r   <= {dev_r, blk_r, 1'b1, hbc_pkg::COUNT_ONE, home, RANK_TOP};
      end else begin
        res_entry_r  <= 5'd0;
        res_status_r <= hbc_pkg::STAT_NO_FREE;
      end
    end
    // release, pin, unpin decision
    if (cmd.eval_entry) begin
      if (cmd_r != hbc_pkg::CMD_PIN && rd_cnt == '0) begin
        res_status_r <= hbc_pkg::STAT_UNDERFLOW;
      end
      tgt_idx_r  <= idx_a;
      old_rank_r <= rd_rank;
      tgt_rec_r  <= {rd_dev, rd_blk, rd_valid, 6'd0, rd_bkt, RANK_TOP};
    end
  end

  assign out_entry_out = res_entry_r;
  assign out_hit       = res_hit_r;
  assign out_need_read = res_need_r;
  assign out_status    = res_status_r;

endmodule

@@ rtl/hbc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbc_ctrl
// Sequencer of the tag store: clearing pass, remainder, scan, decision,
// rank sweep and result strobe.
// ----------------------------------------------------------------------------
module hbc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  hbc_pkg::hbc_stat_t stat,
  output hbc_pkg::hbc_cmd_t  cmd
);

  hbc_pkg::hbc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      hbc_pkg::ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_done) begin
          cmd.clear_wr = 1'b1;
          state_nxt    = hbc_pkg::ST_IDLE;
        end
      end
      hbc_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          if (stat.in_get) begin
            state_nxt = hbc_pkg::ST_MOD;
          end else if (stat.in_idx_ok) begin
            state_nxt = hbc_pkg::ST_FETCH;
          end else begin
            state_nxt = hbc_pkg::ST_RESP;
          end
        end
      end
      hbc_pkg::ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_done) begin
          cmd.mod_step = 1'b1;
          cmd.cnt_clr  = 1'b1;
          state_nxt    = hbc_pkg::ST_SCAN;
        end
      end
      hbc_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = hbc_pkg::ST_EVAL;
        end
      end
      hbc_pkg::ST_EVAL: begin
        cmd.eval_get = 1'b1;
        state_nxt    = stat.need_sweep ? hbc_pkg::ST_SWEEP : hbc_pkg::ST_RESP;
      end
      hbc_pkg::ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = hbc_pkg::ST_ENTRY;
      end
      hbc_pkg::ST_ENTRY: begin
        cmd.eval_entry = 1'b1;
        state_nxt      = stat.need_sweep ? hbc_pkg::ST_SWEEP : hbc_pkg::ST_RESP;
      end
      hbc_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.scan_done) begin
          state_nxt = hbc_pkg::ST_RESP;
        end
      end
      hbc_pkg::ST_RESP: begin
        state_nxt = hbc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = hbc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != hbc_pkg::ST_IDLE;
  assign out_valid = state_r == hbc_pkg::ST_RESP;

`ifndef SYNTHESIS
  // a result strobe never comes two in a row and is followed by idle
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe repeated");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted without going busy");

  // a sweep is entered only from a decision state
  a_sweep_entry: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hbc_pkg::ST_SWEEP && $past(state_r) != hbc_pkg::ST_SWEEP |->
    $past(state_r) == hbc_pkg::ST_EVAL || $past(state_r) == hbc_pkg::ST_ENTRY)
    else $error("sweep entered from a wrong state");
`endif

endmodule
